[rtl/rctm_pkg.sv]
// rctm_pkg: shared types and constants of the radio channel table
// used by every module of the block; no dependencies

package rctm_pkg;

  // table size and derived widths
  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_RES  = 8;
  localparam int CNT_W    = $clog2(MAX_RES + 1);

  // stream payload widths
  localparam int IN_BITS  = 68;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 56;

  // configuration port
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_OWN_DN    = 3'd0;
  localparam logic [2:0] REG_PWR_TYPE  = 3'd1;
  localparam logic [2:0] REG_FIT_TYPE  = 3'd2;
  localparam logic [2:0] REG_PWR_TRANS = 3'd3;
  localparam logic [2:0] REG_FIT_TRANS = 3'd4;

  localparam logic [15:0] OWN_DN_RST    = 16'd0;
  localparam logic [7:0]  PWR_TYPE_RST  = 8'd11;
  localparam logic [7:0]  FIT_TYPE_RST  = 8'd17;
  localparam logic [7:0]  PWR_TRANS_RST = 8'd5;
  localparam logic [7:0]  FIT_TRANS_RST = 8'd5;

  // bit masks
  localparam logic [7:0] PAIR_MASK   = 8'h80;
  localparam logic [7:0] TYPE_MASK   = 8'h7F;
  localparam logic [7:0] BGSCAN_MASK = 8'h01;
  localparam logic [7:0] STATE_MASK  = 8'h03;
  localparam logic [7:0] NET_MASK    = 8'h0C;
  localparam logic [7:0] CTYPE_MASK  = 8'hF0;

  localparam logic [1:0] ASG_NONE = 2'd0;
  localparam logic [1:0] ASG_DONE = 2'd1;

  localparam logic [1:0] LDEV_NONE    = 2'd0;
  localparam logic [1:0] LDEV_POWER   = 2'd1;
  localparam logic [1:0] LDEV_FITNESS = 2'd2;

  typedef enum logic [3:0] {
    OP_RESET        = 4'd0,
    OP_UNASSIGN     = 4'd1,
    OP_ASSIGN       = 4'd2,
    OP_SET_ID       = 4'd3,
    OP_SET_SETTING  = 4'd4,
    OP_OPEN         = 4'd5,
    OP_CLOSE        = 4'd6,
    OP_SCAN_OPEN    = 4'd7,
    OP_QUERY_STATUS = 4'd8,
    OP_QUERY_ID     = 4'd9,
    OP_ACK_DATA     = 4'd10,
    OP_TX_EVENT     = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_WRONG_STATE = 3'd1,
    RC_ID_NOT_SET  = 3'd2,
    RC_INVALID_MSG = 3'd3,
    RC_INVALID_REQ = 3'd4,
    RC_NO_MATCH    = 3'd5,
    RC_STARTUP     = 3'd6
  } rc_e;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  xmit_type;
    logic [7:0]  dev_type;
    logic [15:0] device_number;
    logic [7:0]  extended_assign;
    logic [7:0]  network_number;
    logic [7:0]  channel_type;
    logic [7:0]  channel;
    logic [3:0]  opcode;
  } item_t;

  // result item without the last flag, last field in the lowest bits
  typedef struct packed {
    logic        stop_devices;
    logic        start_fitness;
    logic        start_power;
    logic [1:0]  local_device;
    logic [7:0]  out_xmit_type;
    logic [7:0]  out_dev_type;
    logic [15:0] out_device_number;
    logic [7:0]  status_byte;
    logic [7:0]  out_channel;
    rc_e         response_code;
  } res_t;

  typedef struct packed {
    logic [15:0] own_dn;
    logic [7:0]  pwr_type;
    logic [7:0]  fit_type;
    logic [7:0]  pwr_trans;
    logic [7:0]  fit_trans;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic            item_load;
    logic            exec;
    logic            scan;
    logic [CH_W-1:0] scan_idx;
    logic            scan_step;
    logic            pend_cap;
    logic            emit_pend;
    logic            emit_last;
    logic            emit_nomatch;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic match_hit;
    logic in_tx;
  } dp_sts_t;

endpackage

[rtl/radio_channel_table_with_id_match_top.sv]
// radio_channel_table_with_id_match_top: top level of the radio channel table
// depends on rctm_pkg, rctm_regs, rctm_ctrl and rctm_dp
//
// Usage:
// - s_axis carries one command per transfer; m_axis returns its results, the
//   final result of each command marked by m_axis_tlast.
// - every opcode but the transmit event gives exactly one result; a transmit
//   event gives one result per matching open channel (at most 8, in channel
//   order) or a single no-match result.
// - a command other than a transmit event is registered on its transfer and
//   executed into the output register once that has room; the next command is
//   taken only after that, so no new command is taken while one is in flight.
// - a transmit event walks the table one channel per cycle, set by the single
//   table read port, except while a held match waits for the output register.
// - the output register holds one result; while the sink stalls, one more
//   command can still be taken; then execution, a held match's release and
//   the walk's end wait for the register, and s_axis_tready stays low.
// - reset (rst_ni low) empties the table, drops any pending result and loads
//   the register reset values; the reset opcode empties the table only.
// - the apb registers are meant to be written while no command is in flight.

module radio_channel_table_with_id_match_top import rctm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // opcode[3:0], channel[11:4], channel_type[19:12], network_number[27:20],
  // extended_assign[35:28], device_number[51:36], dev_type[59:52],
  // xmit_type[67:60], zero fill[71:68]
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // response_code[2:0], out_channel[10:3], status_byte[18:11],
  // out_device_number[34:19], out_dev_type[42:35], out_xmit_type[50:43],
  // local_device[52:51], start_power[53], start_fitness[54], stop_devices[55]
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign pready = 1'b1;

  rctm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  rctm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rctm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[rtl/rctm_regs.sv]
// rctm_regs: apb register file with the local device identities
// depends on rctm_pkg

module rctm_regs import rctm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = paddr_i[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_dn    <= OWN_DN_RST;
      cfg_q.pwr_type  <= PWR_TYPE_RST;
      cfg_q.fit_type  <= FIT_TYPE_RST;
      cfg_q.pwr_trans <= PWR_TRANS_RST;
      cfg_q.fit_trans <= FIT_TRANS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_DN:    cfg_q.own_dn    <= pwdata_i[15:0];
        REG_PWR_TYPE:  cfg_q.pwr_type  <= pwdata_i[7:0];
        REG_FIT_TYPE:  cfg_q.fit_type  <= pwdata_i[7:0];
        REG_PWR_TRANS: cfg_q.pwr_trans <= pwdata_i[7:0];
        REG_FIT_TRANS: cfg_q.fit_trans <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    case (reg_idx)
      REG_OWN_DN:    prdata_o = {16'd0, cfg_q.own_dn};
      REG_PWR_TYPE:  prdata_o = {24'd0, cfg_q.pwr_type};
      REG_FIT_TYPE:  prdata_o = {24'd0, cfg_q.fit_type};
      REG_PWR_TRANS: prdata_o = {24'd0, cfg_q.pwr_trans};
      REG_FIT_TRANS: prdata_o = {24'd0, cfg_q.fit_trans};
      default:       prdata_o = '0;
    endcase
  end

endmodule

[rtl/rctm_ctrl.sv]
// rctm_ctrl: sequencer for commands and the transmit event channel scan
// depends on rctm_pkg

module rctm_ctrl import rctm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_CMD, S_SCAN, S_DONE} state_e;

  state_e           state_q;
  logic [CH_W-1:0]  idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pend_q;
  logic             hit_take;
  logic             stall;

  // a match beyond the result limit still learns but is not reported
  assign hit_take   = sts_i.match_hit & (cnt_q < CNT_W'(MAX_RES));
  // the held match can only move on once the output register has room
  assign stall      = hit_take & pend_q & sts_i.out_busy;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.scan_idx = idx_q;
    case (state_q)
      S_IDLE: cmd_o.item_load = in_valid_i;
      S_CMD:  cmd_o.exec = ~sts_i.out_busy;
      S_SCAN: begin
        if (!stall) begin
          cmd_o.scan_step = 1'b1;
          if (hit_take) begin
            cmd_o.emit_pend = pend_q;
            cmd_o.pend_cap  = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_pend    = pend_q;
          cmd_o.emit_last    = pend_q;
          cmd_o.emit_nomatch = ~pend_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.in_tx ? S_SCAN : S_CMD;
            idx_q   <= '0;
            cnt_q   <= '0;
            pend_q  <= 1'b0;
          end
        end
        S_CMD: begin
          if (!sts_i.out_busy) state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (!stall) begin
            if (hit_take) begin
              pend_q <= 1'b1;
              cnt_q  <= cnt_q + 1'b1;
            end
            if (idx_q == CH_W'(CHANNELS - 1)) state_q <= S_DONE;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_DONE: begin
          if (!sts_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/rctm_dp.sv]
// rctm_dp: channel table, command execution, id match and output register
// depends on rctm_pkg

module rctm_dp import rctm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic [IN_W-1:0] in_data_i,
  input  ctrl_cmd_t       cmd_i,
  output dp_sts_t         sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OUT_W-1:0] out_data_o,
  output logic            out_last_o
);

  function automatic logic id_hit(input logic        open,
                                  input logic [15:0] dn_s,
                                  input logic [7:0]  dt_s,
                                  input logic [7:0]  tt_s,
                                  input logic [15:0] dn_k,
                                  input logic [7:0]  dt_k,
                                  input logic [7:0]  tt_k);
    return open && (dn_s == dn_k || dn_s == '0) && (dt_s == dt_k || dt_s == '0) &&
           (tt_s == tt_k || tt_s == '0);
  endfunction

  item_t item_q;
  item_t in_item;

  // channel table
  logic [1:0]          asg_q   [CHANNELS];
  logic [7:0]          ctype_q [CHANNELS];
  logic [7:0]          net_q   [CHANNELS];
  logic [7:0]          ext_q   [CHANNELS];
  logic [15:0]         dn_q    [CHANNELS];
  logic [7:0]          dt_q    [CHANNELS];
  logic [7:0]          tt_q    [CHANNELS];
  logic [CHANNELS-1:0] open_q;

  logic [CH_W-1:0]     pend_idx_q;
  res_t                out_q;
  logic                out_valid_q;
  logic                out_last_q;

  logic                ch_ok;
  logic [CH_W-1:0]     cidx;
  logic [CH_W-1:0]     rd_idx;
  logic [1:0]          rd_asg;
  logic [7:0]          rd_ctype;
  logic [7:0]          rd_net;
  logic [7:0]          rd_ext;
  logic [15:0]         rd_dn;
  logic [7:0]          rd_dt;
  logic [7:0]          rd_tt;
  logic                rd_open;
  logic [CHANNELS-1:0] csel;
  logic                scan_hit;
  logic                learn;

  res_t                ex;
  logic                clr_all;
  logic                wr_asg;
  logic [1:0]          asg_val;
  logic                wr_bytes;
  logic                wr_id_ex;
  logic                wr_open;
  logic                open_val;
  logic                wr_id;
  logic [7:0]          dt_w;
  logic                out_load;
  res_t                out_d;
  logic                out_last_d;

  assign in_item = item_t'(in_data_i[IN_BITS-1:0]);

  assign ch_ok  = item_q.channel < 8'(CHANNELS);
  assign cidx   = ch_ok ? item_q.channel[CH_W-1:0] : '0;
  assign rd_idx = cmd_i.scan ? cmd_i.scan_idx : cidx;

  assign rd_asg   = asg_q[rd_idx];
  assign rd_ctype = ctype_q[rd_idx];
  assign rd_net   = net_q[rd_idx];
  assign rd_ext   = ext_q[rd_idx];
  assign rd_dn    = dn_q[rd_idx];
  assign rd_dt    = dt_q[rd_idx];
  assign rd_tt    = tt_q[rd_idx];
  assign rd_open  = open_q[rd_idx];

  always_comb begin
    csel       = '0;
    csel[cidx] = 1'b1;
  end

  assign scan_hit = id_hit(rd_open, rd_dn, rd_dt, rd_tt,
                           item_q.device_number, item_q.dev_type, item_q.xmit_type);
  assign learn    = cmd_i.scan_step & scan_hit & ((rd_ext & BGSCAN_MASK) == '0);

  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;
  assign sts_o.match_hit = scan_hit;
  assign sts_o.in_tx     = (op_e'(in_item.opcode) == OP_TX_EVENT);

  // single command: answer and update of its channel; reset clears the table
  always_comb begin
    ex             = '0;
    ex.out_channel = item_q.channel;
    clr_all        = 1'b0;
    wr_asg         = 1'b0;
    asg_val        = ASG_NONE;
    wr_bytes       = 1'b0;
    wr_id_ex       = 1'b0;
    wr_open        = 1'b0;
    open_val       = 1'b0;
    case (op_e'(item_q.opcode))
      OP_RESET: begin
        ex.response_code = RC_STARTUP;
        ex.stop_devices  = 1'b1;
        clr_all          = 1'b1;
      end
      OP_UNASSIGN: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else if (rd_asg != ASG_NONE) wr_asg = 1'b1;
        else ex.response_code = RC_WRONG_STATE;
      end
      OP_ASSIGN: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else if (rd_asg == ASG_NONE) begin
          wr_asg   = 1'b1;
          asg_val  = ASG_DONE;
          wr_bytes = 1'b1;
        end else ex.response_code = RC_WRONG_STATE;
      end
      OP_SET_ID: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else if (rd_asg != ASG_NONE) wr_id_ex = 1'b1;
        else ex.response_code = RC_WRONG_STATE;
      end
      OP_SET_SETTING: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else if (rd_asg == ASG_NONE) ex.response_code = RC_WRONG_STATE;
      end
      OP_OPEN: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else begin
          if (rd_asg != ASG_NONE) begin
            wr_open  = 1'b1;
            open_val = 1'b1;
          end else ex.response_code = RC_ID_NOT_SET;
          ex.start_power   = (rd_dt == cfg_i.pwr_type) || (rd_dt == '0);
          ex.start_fitness = (rd_dt == cfg_i.fit_type) || (rd_dt == '0);
        end
      end
      OP_CLOSE: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else begin
          wr_open         = 1'b1;
          ex.stop_devices = ((open_q & ~csel) == '0);
        end
      end
      OP_SCAN_OPEN: begin
        if (!ch_ok) ex.response_code = RC_INVALID_MSG;
        else begin
          if (rd_asg != ASG_NONE) begin
            wr_open  = 1'b1;
            open_val = 1'b1;
          end else ex.response_code = RC_WRONG_STATE;
          ex.start_power   = 1'b1;
          ex.start_fitness = 1'b1;
        end
      end
      OP_QUERY_STATUS: begin
        if (!ch_ok) ex.response_code = RC_INVALID_REQ;
        else ex.status_byte = ({6'd0, rd_asg} & STATE_MASK) | (rd_net & NET_MASK) |
                              (rd_ctype & CTYPE_MASK);
      end
      OP_QUERY_ID: begin
        if (!ch_ok) ex.response_code = RC_INVALID_REQ;
        else begin
          ex.out_device_number = rd_dn;
          ex.out_dev_type      = rd_dt;
          ex.out_xmit_type     = rd_tt;
        end
      end
      OP_ACK_DATA: begin
        // power device takes precedence over fitness device
        if (!ch_ok) ex.local_device = LDEV_NONE;
        else if (id_hit(rd_open, rd_dn, rd_dt, rd_tt,
                        cfg_i.own_dn, cfg_i.pwr_type, cfg_i.pwr_trans))
          ex.local_device = LDEV_POWER;
        else if (id_hit(rd_open, rd_dn, rd_dt, rd_tt,
                        cfg_i.own_dn, cfg_i.fit_type, cfg_i.fit_trans))
          ex.local_device = LDEV_FITNESS;
      end
      default: ex.response_code = RC_INVALID_MSG;
    endcase
  end

  assign wr_id = (cmd_i.exec & wr_id_ex) | learn;
  assign dt_w  = learn ? item_q.dev_type : (item_q.dev_type & TYPE_MASK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asg_q   <= '{default: '0};
      ctype_q <= '{default: '0};
      net_q   <= '{default: '0};
      ext_q   <= '{default: '0};
      dn_q    <= '{default: '0};
      dt_q    <= '{default: '0};
      tt_q    <= '{default: '0};
      open_q  <= '0;
    end else if (cmd_i.exec && clr_all) begin
      asg_q   <= '{default: '0};
      ctype_q <= '{default: '0};
      net_q   <= '{default: '0};
      ext_q   <= '{default: '0};
      dn_q    <= '{default: '0};
      dt_q    <= '{default: '0};
      tt_q    <= '{default: '0};
      open_q  <= '0;
    end else begin
      if (cmd_i.exec && wr_asg) asg_q[rd_idx] <= asg_val;
      if (cmd_i.exec && wr_bytes) begin
        ctype_q[rd_idx] <= item_q.channel_type;
        net_q[rd_idx]   <= item_q.network_number;
        ext_q[rd_idx]   <= item_q.extended_assign;
      end
      if (cmd_i.exec && wr_open) open_q[rd_idx] <= open_val;
      if (wr_id) begin
        dn_q[rd_idx] <= item_q.device_number;
        dt_q[rd_idx] <= dt_w;
        tt_q[rd_idx] <= item_q.xmit_type;
      end
    end
  end

  // output register source select
  always_comb begin
    out_d      = ex;
    out_last_d = 1'b1;
    out_load   = cmd_i.exec | cmd_i.emit_pend | cmd_i.emit_nomatch;
    if (cmd_i.emit_pend) begin
      out_d             = '0;
      out_d.out_channel = 8'(pend_idx_q);
      out_last_d        = cmd_i.emit_last;
    end else if (cmd_i.emit_nomatch) begin
      out_d               = '0;
      out_d.response_code = RC_NO_MATCH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) item_q <= in_item;
    if (cmd_i.pend_cap) pend_idx_q <= cmd_i.scan_idx;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_last_o  = out_last_q;

endmodule

[rtl/rctm_checker.sv]
// rctm_checker: port level checks of the radio channel table, bound to the top
// depends on rctm_pkg and radio_channel_table_with_id_match_top

module rctm_checker import rctm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic              m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one command in flight: no transfer in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  // no-match result always closes its transmit event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == RC_NO_MATCH) |-> m_axis_tlast)
    else $error("no-match result not marked last");

  // table reset answers startup, marked last, with a stop request and no start request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == RC_STARTUP) |->
      m_axis_tlast && m_axis_tdata[55] && !m_axis_tdata[53] && !m_axis_tdata[54])
    else $error("startup result malformed");

endmodule

bind radio_channel_table_with_id_match_top rctm_checker u_rctm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/rctm_checker.sv]
// rctm_scoreboard: scoreboard for the radio channel table; follows the command and
// result streams and the apb writes, predicts every result and compares them
// depends on rctm_pkg only

module rctm_scoreboard import rctm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IN_W-1:0]   cmd_tdata_i,
  input  logic              cmd_tvalid_i,
  input  logic              cmd_tready_i,
  input  logic [OUT_W-1:0]  res_tdata_i,
  input  logic              res_tvalid_i,
  input  logic              res_tready_i,
  input  logic              res_tlast_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output int                mismatches_o,
  output int                outstanding_o,
  output int                compared_o
);

  typedef struct packed {
    logic last;
    res_t res;
  } answer_t;

  // shadow copy of the channel table and registers
  logic [1:0]  chan_asg   [CHANNELS];
  logic [7:0]  chan_ctype [CHANNELS];
  logic [7:0]  chan_net   [CHANNELS];
  logic [7:0]  chan_ext   [CHANNELS];
  logic [15:0] chan_dn    [CHANNELS];
  logic [7:0]  chan_dt    [CHANNELS];
  logic [7:0]  chan_tt    [CHANNELS];
  logic        chan_pair  [CHANNELS];
  logic        chan_open  [CHANNELS];
  logic        scan_on;
  cfg_t        regs;

  answer_t answers_q[$];
  int      mismatches = 0;
  int      compared   = 0;

  assign mismatches_o = mismatches;
  assign compared_o   = compared;

  task automatic wipe_table();
    int i;
    for (i = 0; i < CHANNELS; i++) begin
      chan_asg[i]   = ASG_NONE;
      chan_ctype[i] = '0;
      chan_net[i]   = '0;
      chan_ext[i]   = '0;
      chan_dn[i]    = '0;
      chan_dt[i]    = '0;
      chan_tt[i]    = '0;
      chan_pair[i]  = 1'b0;
      chan_open[i]  = 1'b0;
    end
    scan_on = 1'b0;
  endtask

  function automatic logic any_chan_open();
    int i;
    any_chan_open = 1'b0;
    for (i = 0; i < CHANNELS; i++)
      if (chan_open[i]) any_chan_open = 1'b1;
  endfunction

  // zero in a stored id field matches anything
  function automatic logic id_hit(int c, logic [15:0] dn, logic [7:0] dt, logic [7:0] tt);
    id_hit = chan_open[c] &&
             (chan_dn[c] == dn || chan_dn[c] == '0) &&
             (chan_dt[c] == dt || chan_dt[c] == '0) &&
             (chan_tt[c] == tt || chan_tt[c] == '0);
  endfunction

  task automatic predict(item_t it);
    answer_t a;
    int      n;
    int      i;
    int      c;
    logic    valid;
    a     = '0;
    n     = 0;
    valid = it.channel < CHANNELS;
    c     = valid ? int'(it.channel) : 0;
    if (it.opcode == OP_TX_EVENT) begin
      for (i = 0; i < CHANNELS; i++) begin
        if (id_hit(i, it.device_number, it.dev_type, it.xmit_type)) begin
          if ((chan_ext[i] & BGSCAN_MASK) == '0) begin
            chan_dn[i] = it.device_number;
            chan_dt[i] = it.dev_type;
            chan_tt[i] = it.xmit_type;
          end
          if (n < MAX_RES) begin
            a = '0;
            a.res.response_code = RC_OK;
            a.res.out_channel   = 8'(i);
            answers_q.push_back(a);
            n++;
          end
        end
      end
      if (n == 0) begin
        a = '0;
        a.res.response_code = RC_NO_MATCH;
        answers_q.push_back(a);
      end
      answers_q[answers_q.size()-1].last = 1'b1;
    end else begin
      a.last = 1'b1;
      a.res.response_code = RC_OK;
      a.res.out_channel   = it.channel;
      case (it.opcode)
        OP_RESET: begin
          wipe_table();
          a.res.response_code = RC_STARTUP;
          a.res.stop_devices  = 1'b1;
        end
        OP_UNASSIGN, OP_ASSIGN, OP_SET_ID, OP_SET_SETTING, OP_OPEN, OP_CLOSE,
        OP_SCAN_OPEN: begin
          if (!valid) begin
            a.res.response_code = RC_INVALID_MSG;
          end else begin
            case (it.opcode)
              OP_UNASSIGN: begin
                if (chan_asg[c] != ASG_NONE) chan_asg[c] = ASG_NONE;
                else a.res.response_code = RC_WRONG_STATE;
              end
              OP_ASSIGN: begin
                if (chan_asg[c] == ASG_NONE) begin
                  chan_asg[c]   = ASG_DONE;
                  chan_ctype[c] = it.channel_type;
                  chan_net[c]   = it.network_number;
                  chan_ext[c]   = it.extended_assign;
                end else begin
                  a.res.response_code = RC_WRONG_STATE;
                end
              end
              OP_SET_ID: begin
                if (chan_asg[c] != ASG_NONE) begin
                  chan_dn[c]   = it.device_number;
                  chan_pair[c] = (it.dev_type & PAIR_MASK) != '0;
                  chan_dt[c]   = it.dev_type & TYPE_MASK;
                  chan_tt[c]   = it.xmit_type;
                end else begin
                  a.res.response_code = RC_WRONG_STATE;
                end
              end
              OP_SET_SETTING: begin
                if (chan_asg[c] == ASG_NONE) a.res.response_code = RC_WRONG_STATE;
              end
              OP_OPEN: begin
                // start requests go out even when the open itself is refused
                if (chan_asg[c] != ASG_NONE) chan_open[c] = 1'b1;
                else a.res.response_code = RC_ID_NOT_SET;
                a.res.start_power   = chan_dt[c] == regs.pwr_type || chan_dt[c] == '0;
                a.res.start_fitness = chan_dt[c] == regs.fit_type || chan_dt[c] == '0;
              end
              OP_CLOSE: begin
                chan_open[c] = 1'b0;
                if (c == 0) scan_on = 1'b0;
                a.res.stop_devices = !any_chan_open();
              end
              default: begin
                if (chan_asg[c] != ASG_NONE) begin
                  chan_open[c] = 1'b1;
                  scan_on      = 1'b1;
                end else begin
                  a.res.response_code = RC_WRONG_STATE;
                end
                a.res.start_power   = 1'b1;
                a.res.start_fitness = 1'b1;
              end
            endcase
          end
        end
        OP_QUERY_STATUS: begin
          if (!valid) a.res.response_code = RC_INVALID_REQ;
          else a.res.status_byte = ({6'b0, chan_asg[c]} & STATE_MASK) |
                                   (chan_net[c] & NET_MASK) | (chan_ctype[c] & CTYPE_MASK);
        end
        OP_QUERY_ID: begin
          if (!valid) begin
            a.res.response_code = RC_INVALID_REQ;
          end else begin
            a.res.out_device_number = chan_dn[c];
            a.res.out_dev_type      = chan_dt[c];
            a.res.out_xmit_type     = chan_tt[c];
          end
        end
        OP_ACK_DATA: begin
          // power device wins over fitness; out of range is simply no match
          if (valid) begin
            if (id_hit(c, regs.own_dn, regs.pwr_type, regs.pwr_trans))
              a.res.local_device = LDEV_POWER;
            else if (id_hit(c, regs.own_dn, regs.fit_type, regs.fit_trans))
              a.res.local_device = LDEV_FITNESS;
          end
        end
        default: a.res.response_code = RC_INVALID_MSG;
      endcase
      answers_q.push_back(a);
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_answer(logic [OUT_W-1:0] d, logic l);
    res_t    got;
    answer_t want;
    got = res_t'(d);
    compared++;
    if (answers_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, code", 16'(got.response_code), '0);
    end else begin
      want = answers_q.pop_front();
      if (got.response_code !== want.res.response_code)
        report_mismatch("response_code", 16'(got.response_code), 16'(want.res.response_code));
      if (got.out_channel !== want.res.out_channel)
        report_mismatch("out_channel", 16'(got.out_channel), 16'(want.res.out_channel));
      if (got.status_byte !== want.res.status_byte)
        report_mismatch("status_byte", 16'(got.status_byte), 16'(want.res.status_byte));
      if (got.out_device_number !== want.res.out_device_number)
        report_mismatch("out_device_number", got.out_device_number,
                        want.res.out_device_number);
      if (got.out_dev_type !== want.res.out_dev_type)
        report_mismatch("out_dev_type", 16'(got.out_dev_type),
                        16'(want.res.out_dev_type));
      if (got.out_xmit_type !== want.res.out_xmit_type)
        report_mismatch("out_xmit_type", 16'(got.out_xmit_type),
                        16'(want.res.out_xmit_type));
      if (got.local_device !== want.res.local_device)
        report_mismatch("local_device", 16'(got.local_device), 16'(want.res.local_device));
      if (got.start_power !== want.res.start_power)
        report_mismatch("start_power", 16'(got.start_power), 16'(want.res.start_power));
      if (got.start_fitness !== want.res.start_fitness)
        report_mismatch("start_fitness", 16'(got.start_fitness), 16'(want.res.start_fitness));
      if (got.stop_devices !== want.res.stop_devices)
        report_mismatch("stop_devices", 16'(got.stop_devices), 16'(want.res.stop_devices));
      if (l !== want.last)
        report_mismatch("tlast", 16'(l), 16'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_table();
      regs = {OWN_DN_RST, PWR_TYPE_RST, FIT_TYPE_RST, PWR_TRANS_RST, FIT_TRANS_RST};
      answers_q.delete();
      outstanding_o <= 0;
    end else begin
      // a result never belongs to the command taken at the same edge
      if (res_tvalid_i && res_tready_i) check_answer(res_tdata_i, res_tlast_i);
      if (cmd_tvalid_i && cmd_tready_i) predict(item_t'(cmd_tdata_i[IN_BITS-1:0]));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_OWN_DN:    regs.own_dn    = pwdata_i[15:0];
          REG_PWR_TYPE:  regs.pwr_type  = pwdata_i[7:0];
          REG_FIT_TYPE:  regs.fit_type  = pwdata_i[7:0];
          REG_PWR_TRANS: regs.pwr_trans = pwdata_i[7:0];
          REG_FIT_TRANS: regs.fit_trans = pwdata_i[7:0];
          default: ;
        endcase
      end
      outstanding_o <= answers_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// tb: stimulus and verdict for radio_channel_table_with_id_match_top
// drives commands, result back-pressure and register writes; rctm_scoreboard scores
// depends on rctm_pkg, rctm_scoreboard and the block's rtl

module tb;
  import rctm_pkg::*;

  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   mismatches;
  int   outstanding;
  int   compared;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_req = 0;
  int   hold_left = 0;
  int   n_cmds = 0;
  int   n_settings = 0;
  cfg_t cfg_now;

  always #5 clk = ~clk;

  radio_channel_table_with_id_match_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rctm_scoreboard u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cmd_tdata_i   (s_axis_tdata),
    .cmd_tvalid_i  (s_axis_tvalid),
    .cmd_tready_i  (s_axis_tready),
    .res_tdata_i   (m_axis_tdata),
    .res_tvalid_i  (m_axis_tvalid),
    .res_tready_i  (m_axis_tready),
    .res_tlast_i   (m_axis_tlast),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  // result sink: random stalls, or a long hold-off counted here when asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= rx_idle_pct;
    end
  end

  function automatic item_t cmd(logic [3:0] op, logic [7:0] ch, logic [7:0] ctype,
                                logic [7:0] net, logic [7:0] ext, logic [15:0] dn,
                                logic [7:0] dt, logic [7:0] tt);
    item_t it;
    it.opcode          = op;
    it.channel         = ch;
    it.channel_type    = ctype;
    it.network_number  = net;
    it.extended_assign = ext;
    it.device_number   = dn;
    it.dev_type        = dt;
    it.xmit_type       = tt;
    return it;
  endfunction

  function automatic item_t rand_cmd();
    item_t it;
    it.opcode          = 4'($urandom_range(15));
    it.channel         = $urandom_range(1) ? 8'($urandom_range(CHANNELS - 1))
                                           : 8'($urandom_range(255));
    it.channel_type    = 8'($urandom_range(255));
    it.network_number  = 8'($urandom_range(255));
    it.extended_assign = 8'($urandom_range(255));
    it.device_number   = 16'($urandom_range(65535));
    it.dev_type        = 8'($urandom_range(255));
    it.xmit_type       = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_cmd(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, it};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_cmds++;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] dn, logic [7:0] pt, logic [7:0] ft,
                            logic [7:0] ptr, logic [7:0] ftr);
    apb_write(REG_OWN_DN, 32'(dn));
    apb_write(REG_PWR_TYPE, 32'(pt));
    apb_write(REG_FIT_TYPE, 32'(ft));
    apb_write(REG_PWR_TRANS, 32'(ptr));
    apb_write(REG_FIT_TRANS, 32'(ftr));
    cfg_now = {dn, pt, ft, ptr, ftr};
    n_settings++;
  endtask

  // stop offering and wait for every outstanding result, then a table walk's worth
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // assign, usually set id, open, some traffic, then half the time close down again
  task automatic run_session();
    logic [7:0]  ch;
    logic [15:0] dn;
    logic [7:0]  dt;
    logic [7:0]  tt;
    ch = 8'($urandom_range(CHANNELS - 1));
    case ($urandom_range(4))
      0, 1: begin
        dn = cfg_now.own_dn;
        dt = cfg_now.pwr_type;
        tt = cfg_now.pwr_trans;
      end
      2: begin
        dn = cfg_now.own_dn;
        dt = cfg_now.fit_type;
        tt = cfg_now.fit_trans;
      end
      default: begin
        dn = $urandom_range(1) ? 16'h0000 : 16'($urandom_range(65535));
        dt = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
        tt = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
      end
    endcase
    send_cmd(cmd(OP_ASSIGN, ch, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), '0, '0, '0));
    if ($urandom_range(3) != 0)
      send_cmd(cmd(OP_SET_ID, ch, '0, '0, '0, dn,
                   (dt & TYPE_MASK) | ($urandom_range(1) ? PAIR_MASK : 8'h00), tt));
    send_cmd(cmd($urandom_range(4) == 0 ? OP_SCAN_OPEN : OP_OPEN, ch, '0, '0, '0, '0, '0, '0));
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(5))
        0, 1: send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, dn, dt & TYPE_MASK, tt));
        2: send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, 16'($urandom_range(65535)),
                        8'($urandom_range(255)), 8'($urandom_range(255))));
        3: send_cmd(cmd(OP_ACK_DATA, ch, '0, '0, '0, '0, '0, '0));
        4: send_cmd(cmd(OP_QUERY_STATUS, ch, '0, '0, '0, '0, '0, '0));
        default: send_cmd(cmd(OP_QUERY_ID, ch, '0, '0, '0, '0, '0, '0));
      endcase
    end
    if ($urandom_range(1)) begin
      send_cmd(cmd(OP_CLOSE, ch, '0, '0, '0, '0, '0, '0));
      send_cmd(cmd(OP_UNASSIGN, ch, '0, '0, '0, '0, '0, '0));
    end
  endtask

  task automatic run_random(int n);
    int start;
    start = n_cmds;
    while (n_cmds - start < n) begin
      if ($urandom_range(2) != 0) run_session();
      else send_cmd(rand_cmd());
    end
  endtask

  initial begin
    int          k;
    logic [15:0] flood_dn;
    logic [7:0]  flood_dt;
    logic [7:0]  flood_tt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 68;
    set_config(OWN_DN_RST, PWR_TYPE_RST, FIT_TYPE_RST, PWR_TRANS_RST, FIT_TRANS_RST);

    send_cmd(cmd(OP_RESET, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_UNASSIGN, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_ASSIGN, 8'd0, 8'hFF, 8'hFF, 8'h00, '0, '0, '0));
    send_cmd(cmd(OP_ASSIGN, 8'd0, 8'h12, 8'h34, 8'h00, '0, '0, '0));
    send_cmd(cmd(OP_ASSIGN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '0, '0, '0));
    send_cmd(cmd(OP_QUERY_STATUS, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_QUERY_STATUS, 8'd8, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_SET_ID, 8'd1, '0, '0, '0, 16'h1234, 8'h05, 8'h05));
    send_cmd(cmd(OP_SET_ID, 8'd0, '0, '0, '0, 16'hFFFF, 8'hFF, 8'hFF));
    send_cmd(cmd(OP_QUERY_ID, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_QUERY_ID, 8'h80, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_SET_SETTING, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_SET_SETTING, 8'd5, '0, '0, '0, '0, '0, '0));
    // unassigned channel still raises both start requests
    send_cmd(cmd(OP_OPEN, 8'd5, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_OPEN, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_ASSIGN, 8'd1, 8'h00, 8'h00, BGSCAN_MASK, '0, '0, '0));
    send_cmd(cmd(OP_SCAN_OPEN, 8'd1, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_SCAN_OPEN, 8'd2, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_ASSIGN, 8'd2, 8'h00, 8'h00, 8'h00, '0, '0, '0));
    send_cmd(cmd(OP_SET_ID, 8'd2, '0, '0, '0, OWN_DN_RST, PWR_TYPE_RST, PWR_TRANS_RST));
    send_cmd(cmd(OP_OPEN, 8'd2, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_ACK_DATA, 8'd2, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_SET_ID, 8'd1, '0, '0, '0, OWN_DN_RST, FIT_TYPE_RST, FIT_TRANS_RST));
    send_cmd(cmd(OP_ACK_DATA, 8'd1, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_ACK_DATA, 8'd9, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, OWN_DN_RST, FIT_TYPE_RST, FIT_TRANS_RST));
    send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, 16'hFFFF, TYPE_MASK, 8'hFF));
    // closing channel 0 drops scan mode; stop only once the last one shuts
    send_cmd(cmd(OP_CLOSE, 8'd0, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_CLOSE, 8'd1, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_CLOSE, 8'd2, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, 16'hFFFF, 8'hFF, 8'hFF));
    send_cmd(cmd(OP_UNUSED_LO, 8'd3, '0, '0, '0, '0, '0, '0));
    send_cmd(cmd(OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
    run_random(10);

    wait_idle();
    tx_idle_pct = 68;
    rx_idle_pct = 14;
    set_config(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    run_random(20);

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(16'($urandom_range(65535)), 8'($urandom_range(127)),
               8'($urandom_range(127)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    // every channel open with a wildcard id, then flood while the sink holds off
    send_cmd(cmd(OP_RESET, 8'($urandom_range(255)), '0, '0, '0, '0, '0, '0));
    for (k = 0; k < CHANNELS; k++) begin
      send_cmd(cmd(OP_ASSIGN, 8'(k), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'h00, '0, '0, '0));
      send_cmd(cmd(OP_OPEN, 8'(k), '0, '0, '0, '0, '0, '0));
    end
    flood_dn = 16'($urandom_range(65535));
    flood_dt = 8'($urandom_range(255));
    flood_tt = 8'($urandom_range(255));
    hold_req = 150;
    repeat (6) send_cmd(cmd(OP_TX_EVENT, '0, '0, '0, '0, flood_dn, flood_dt, flood_tt));
    wait_idle();
    run_random(15);

    wait_idle();
    set_config(16'h0000, 8'h00, TYPE_MASK, 8'h00, 8'hFF);
    run_random(6);

    wait_idle();
    $display("covered %0d commands over %0d register settings, %0d results compared",
             n_cmds, n_settings, compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[radio_channel_table_with_id_match_top] OK");
    end else begin
      $display("[radio_channel_table_with_id_match_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("[radio_channel_table_with_id_match_top] ERROR");
    $finish;
  end

endmodule
